### src/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and constants for the RGB to HSV converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

   // Hue sector, picked by the largest channel (red, then green, then blue on ties)
   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   localparam int HUE_DEG_SEXTANT = 60;
   localparam int HUE_DEG_FULL    = 360;
   localparam int GREEN_BASE      = 2;
   localparam int BLUE_BASE       = 4;

endpackage

`default_nettype wire

### src/rhc_div.sv
// ----------------------------------------------------------------------------
// rhc_div
// Pipelined restoring divider, one quotient bit per register stage.
// Requires num < den * 2^QUO_BITS.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_div #(
   parameter int DIV_BITS = 8,
   parameter int QUO_BITS = 10
) (
   input  wire logic                         clock,
   input  wire logic [QUO_BITS-1:0]          stage_en,
   input  wire logic [DIV_BITS+QUO_BITS-1:0] num,
   input  wire logic [DIV_BITS-1:0]          den,
   output logic      [QUO_BITS-1:0]          quo
);

   localparam int NUM_W = DIV_BITS + QUO_BITS;

   logic [QUO_BITS-1:0][DIV_BITS-1:0] rem_src, rem_in, rem_ff;
   logic [QUO_BITS-1:0][QUO_BITS-1:0] word_src, word_in, word_ff;
   logic [QUO_BITS-1:0][DIV_BITS-1:0] den_src, den_ff;
   logic [QUO_BITS-1:0][DIV_BITS:0]   trial;
   logic [QUO_BITS-1:0]               fits;

   always_comb begin
      rem_src[0]  = num[NUM_W-1:QUO_BITS];
      word_src[0] = num[QUO_BITS-1:0];
      den_src[0]  = den;
      for (int k = 1; k < QUO_BITS; k++) begin
         rem_src[k]  = rem_ff[k-1];
         word_src[k] = word_ff[k-1];
         den_src[k]  = den_ff[k-1];
      end
      for (int k = 0; k < QUO_BITS; k++) begin
         trial[k] = {rem_src[k], word_src[k][QUO_BITS-1]};
         fits[k]  = (trial[k] >= {1'b0, den_src[k]});
         if (fits[k]) begin
            rem_in[k] = DIV_BITS'(trial[k] - {1'b0, den_src[k]});
         end else begin
            rem_in[k] = trial[k][DIV_BITS-1:0];
         end
         word_in[k] = {word_src[k][QUO_BITS-2:0], fits[k]};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QUO_BITS; k++) begin
         if (stage_en[k]) begin
            rem_ff[k]  <= rem_in[k];
            word_ff[k] <= word_in[k];
            den_ff[k]  <= den_src[k];
         end
      end
   end

   assign quo = word_ff[QUO_BITS-1];

endmodule

`default_nettype wire

### src/rgb_to_hsv_convert.sv
// Throughput: one pixel per clock unless rsp_ready stalls the output; each stage
// advances when it is empty or its successor advances, so bubbles close up under
// backpressure.
// Depth is set by the two dividers, which resolve one quotient bit per stage.
// Reset clears only the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert
// RGB pixel to hue (fractional degrees), saturation and value, fully pipelined.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_convert #(
   parameter int CHANNEL_BITS  = 8,
   parameter int HUE_FRAC_BITS = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [CHANNEL_BITS-1:0]    req_red,
   input  wire logic [CHANNEL_BITS-1:0]    req_green,
   input  wire logic [CHANNEL_BITS-1:0]    req_blue,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [HUE_FRAC_BITS+8:0]        rsp_hue,
   output logic [CHANNEL_BITS-1:0]         rsp_saturation,
   output logic [CHANNEL_BITS-1:0]         rsp_brightness,
   output logic                            rsp_hue_undefined
);

   localparam int CW        = CHANNEL_BITS;
   localparam int HW        = HUE_FRAC_BITS + 9;
   localparam int QH        = HUE_FRAC_BITS + 6;
   localparam int QB        = (CW > QH) ? CW : QH;
   localparam int NUM_W     = CW + QB;
   localparam int STAGES    = QB + 3;
   localparam int SIDE_W    = CW + 4;
   localparam int HUE_SCALE = rhc_pkg::HUE_DEG_SEXTANT * (2 ** HUE_FRAC_BITS);
   localparam int HUE_FULL  = rhc_pkg::HUE_DEG_FULL * (2 ** HUE_FRAC_BITS);

   localparam logic [HW-1:0] HUE_FULL_C  = HW'(HUE_FULL);
   localparam logic [HW-1:0] HUE_GREEN_C = HW'(rhc_pkg::GREEN_BASE * HUE_SCALE);
   localparam logic [HW-1:0] HUE_BLUE_C  = HW'(rhc_pkg::BLUE_BASE * HUE_SCALE);
   localparam logic [NUM_W-1:0] HUE_SCALE_C = NUM_W'(HUE_SCALE);

   // ---------------- stage control ----------------
   logic [STAGES-1:0] valid_ff, valid_in, stage_en;

   assign valid_in = {valid_ff[STAGES-2:0], req_valid};

   always_comb begin
      stage_en[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_ready = stage_en[0] && !reset;
   assign rsp_valid = valid_ff[STAGES-1];

   // ---------------- stage 0: max, min, sector ----------------
   logic [CW-1:0]           mx0_in, mn0_in, absdiff0_in;
   logic                    neg0_in;
   rhc_pkg::sector_type     sector0_in;
   logic [CW-1:0]           mx0_ff, delta0_ff, absdiff0_ff;
   logic                    neg0_ff;
   rhc_pkg::sector_type     sector0_ff;

   always_comb begin
      mx0_in = req_red;
      if (req_green > mx0_in) mx0_in = req_green;
      if (req_blue > mx0_in)  mx0_in = req_blue;
      mn0_in = req_red;
      if (req_green < mn0_in) mn0_in = req_green;
      if (req_blue < mn0_in)  mn0_in = req_blue;

      priority if (req_red == mx0_in) begin
         sector0_in  = rhc_pkg::SECTOR_RED;
         neg0_in     = (req_green < req_blue);
         absdiff0_in = neg0_in ? (req_blue - req_green) : (req_green - req_blue);
      end else if (req_green == mx0_in) begin
         sector0_in  = rhc_pkg::SECTOR_GREEN;
         neg0_in     = (req_blue < req_red);
         absdiff0_in = neg0_in ? (req_red - req_blue) : (req_blue - req_red);
      end else begin
         sector0_in  = rhc_pkg::SECTOR_BLUE;
         neg0_in     = (req_red < req_green);
         absdiff0_in = neg0_in ? (req_green - req_red) : (req_red - req_green);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         mx0_ff      <= mx0_in;
         delta0_ff   <= mx0_in - mn0_in;
         absdiff0_ff <= absdiff0_in;
         neg0_ff     <= neg0_in;
         sector0_ff  <= sector0_in;
      end
   end

   // ---------------- stage 1: dividends ----------------
   logic [NUM_W-1:0]  sat_num1_ff, hue_num1_ff;
   logic [CW-1:0]     mx1_ff, delta1_ff;
   logic [SIDE_W-1:0] side1_ff;
   logic [NUM_W-1:0]  hue_bias1;

   // negative green and blue hue is base minus the offset; the offset quotient rounds up
   always_comb begin
      hue_bias1 = (neg0_ff && sector0_ff != rhc_pkg::SECTOR_RED)
                  ? (NUM_W'(delta0_ff) - NUM_W'(1)) : '0;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         sat_num1_ff <= NUM_W'({delta0_ff, {CW{1'b0}}}) - NUM_W'(delta0_ff);
         hue_num1_ff <= NUM_W'(absdiff0_ff) * HUE_SCALE_C + hue_bias1;
         mx1_ff      <= mx0_ff;
         delta1_ff   <= delta0_ff;
         side1_ff    <= {(delta0_ff == '0), sector0_ff, neg0_ff, mx0_ff};
      end
   end

   // ---------------- stages 2 .. QB+1: division ----------------
   logic [QB-1:0] sat_quo, hue_quo;

   rhc_div #(
      .DIV_BITS (CW),
      .QUO_BITS (QB)
   ) u_sat_div (
      .clock    (clock),
      .stage_en (stage_en[2 +: QB]),
      .num      (sat_num1_ff),
      .den      (mx1_ff),
      .quo      (sat_quo)
   );

   rhc_div #(
      .DIV_BITS (CW),
      .QUO_BITS (QB)
   ) u_hue_div (
      .clock    (clock),
      .stage_en (stage_en[2 +: QB]),
      .num      (hue_num1_ff),
      .den      (delta1_ff),
      .quo      (hue_quo)
   );

   logic [QB-1:0][SIDE_W-1:0] side_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < QB; k++) begin
         if (stage_en[2+k]) begin
            side_ff[k] <= (k == 0) ? side1_ff : side_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   // ---------------- final stage: hue assembly and output registers ----------------
   logic [SIDE_W-1:0]   fin_side;
   logic                fin_undef, fin_neg;
   rhc_pkg::sector_type fin_sector;
   logic [HW-1:0]       hue_base, hue_sum, hue_in;
   logic [HW-1:0]       hue_ff;
   logic [CW-1:0]       sat_ff, bright_ff;
   logic                undef_ff;

   always_comb begin
      fin_side   = side_ff[QB-1];
      fin_undef  = fin_side[CW+3];
      fin_sector = rhc_pkg::sector_type'(fin_side[CW+2:CW+1]);
      fin_neg    = fin_side[CW];
      unique case (fin_sector)
         rhc_pkg::SECTOR_RED:   hue_base = fin_neg ? HUE_FULL_C : '0;
         rhc_pkg::SECTOR_GREEN: hue_base = HUE_GREEN_C;
         rhc_pkg::SECTOR_BLUE:  hue_base = HUE_BLUE_C;
         default:               hue_base = '0;
      endcase
      hue_sum = fin_neg ? (hue_base - HW'(hue_quo[QH-1:0]))
                        : (hue_base + HW'(hue_quo[QH-1:0]));
      hue_in  = (fin_undef || hue_sum == HUE_FULL_C) ? '0 : hue_sum;
   end

   always_ff @(posedge clock) begin
      if (stage_en[STAGES-1]) begin
         hue_ff    <= hue_in;
         sat_ff    <= fin_undef ? '0 : sat_quo[CW-1:0];
         bright_ff <= fin_side[CW-1:0];
         undef_ff  <= fin_undef;
      end
   end

   assign rsp_hue           = hue_ff;
   assign rsp_saturation    = sat_ff;
   assign rsp_brightness    = bright_ff;
   assign rsp_hue_undefined = undef_ff;

`ifndef SYNTHESIS
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hue < HUE_FULL_C)
      else $error("hue out of range");

   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hue_undefined |-> rsp_hue == '0 && rsp_saturation == '0)
      else $error("undefined hue with nonzero hue or saturation");

   a_defined_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hue_undefined |-> rsp_saturation != '0 && rsp_brightness != '0)
      else $error("chromatic pixel with zero saturation or value");

   a_pipe_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[STAGES-1] && !rsp_ready |=> $stable(hue_ff) && $stable(sat_ff))
      else $error("output stage changed while stalled");
`endif

endmodule

`default_nettype wire
